// ===== design/assert_macros.svh =====
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== design/cit_pkg.sv =====
package cit_pkg;

    localparam int CIT_CATEGORIES = 7;
    localparam int CIT_CAPACITY   = 256;
    localparam int CIT_KEY_WIDTH  = 64;

    localparam int OP_W        = 2;
    localparam int CAT_FIELD_W = 3;
    localparam int KEY_FIELD_W = 64;
    localparam int SLOT_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int INDEX_W     = 8;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_GET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_CAT  = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_UNFILLED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SEARCH,
        ST_GET_RD,
        ST_GET_WAIT,
        ST_DONE
    } state_t;

endpackage

// ===== design/cit_ram.sv =====
module cit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1792
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/categorized_intern_table_top.sv =====
// Categorized intern table: one insertion-ordered table of keys per category.
// Input words arrive on s_axis (tuser carries op and category, tdata carries
// key and slot). Each input word produces exactly one result word on m_axis
// (tuser carries status, tdata carries found_index and stored_key).
// An add scans its category's entries through one RAM read port, one entry
// per cycle, with a single comparator; a miss appends the key. An add that
// matches at index i stops the scan there, and a miss scans all n entries of
// the category (n its fill count, at most CAPACITY) before it appends or
// reports full. A get reads the slot's entry from the RAM, but skips the read
// for an unfilled index; clear, an unused op or a bad category go from lookup
// straight to the result. The block takes one word at a time: s_axis_tready
// is high only between words and rises with the result. The result sits in
// an output register, so the next word is accepted while a result still
// waits; a word finishing while the previous result is still stalled by
// m_axis_tready holds until that register frees. Reset empties every table
// at once (all fill counts zero) and drops any pending result; the entry RAM
// needs no clearing pass.
module categorized_intern_table_top import cit_pkg::*; #(
    parameter int CATEGORIES = CIT_CATEGORIES,
    parameter int CAPACITY   = CIT_CAPACITY,
    parameter int KEY_WIDTH  = CIT_KEY_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // key[63:0], slot[71:64]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // op[1:0], category[4:2]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // found_index[7:0], stored_key[71:8]
    output logic [M_TUSER_W-1:0] m_axis_tuser   // status[1:0]
);

    localparam int CAT_W  = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int DEPTH  = CATEGORIES * CAPACITY;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int CATX_W = CAT_FIELD_W + 1;

    state_t state_reg, state_next;

    op_t                    op_reg;
    logic [CAT_FIELD_W-1:0] cat_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [SLOT_W-1:0]      slot_reg;

    logic [CNT_W-1:0]  cnt_reg [CATEGORIES];
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;

    status_t                res_status_reg, res_status_next;
    logic [INDEX_W-1:0]     res_idx_reg, res_idx_next;
    logic [KEY_FIELD_W-1:0] res_key_reg, res_key_next;

    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [INDEX_W-1:0]     m_idx_reg, m_idx_next;
    logic [KEY_FIELD_W-1:0] m_key_reg, m_key_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    logic             cnt_clr;
    logic             cnt_inc;
    logic             s_accept;
    logic [CAT_W-1:0] cat_idx;
    logic             cat_ok;
    logic             hit;
    logic             more;
    logic             full;
    logic             slot_ok;
    logic             out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cat_idx       = CAT_W'(cat_reg);
    assign cat_ok        = (CATX_W'(cat_reg) < CATX_W'(CATEGORIES));
    assign hit           = cmp_vld_reg && (ram_rdata == key_reg);
    assign more          = (rd_idx_reg < n_reg);
    assign full          = (n_reg >= CNT_W'(CAPACITY));
    assign slot_ok       = (CMP_W'(slot_reg) < CMP_W'(n_reg));
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_key_reg, m_idx_reg};
    assign m_axis_tuser  = m_status_reg;

    cit_ram #(
        .WIDTH(KEY_WIDTH),
        .DEPTH(DEPTH)
    ) u_entries (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(key_reg),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (op_reg == OP_ADD && cat_ok) begin
                    state_next = ST_SEARCH;
                end else if (op_reg == OP_GET && cat_ok) begin
                    state_next = ST_GET_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    state_next = ST_DONE;
                end else if (!more && !cmp_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_GET_RD: begin
                state_next = slot_ok ? ST_GET_WAIT : ST_DONE;
            end
            ST_GET_WAIT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_next          = n_reg;
        base_next       = base_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_key_next    = res_key_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_status_next   = m_status_reg;
        m_idx_next      = m_idx_reg;
        m_key_next      = m_key_reg;
        ram_we          = 1'b0;
        ram_waddr       = base_reg + ADDR_W'(n_reg);
        ram_re          = 1'b0;
        ram_raddr       = base_reg + ADDR_W'(rd_idx_reg);
        cnt_clr         = 1'b0;
        cnt_inc         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_LOOKUP: begin
                n_next          = cnt_reg[cat_idx];
                base_next       = ADDR_W'(cat_idx) * ADDR_W'(CAPACITY);
                rd_idx_next     = '0;
                cmp_vld_next    = 1'b0;
                res_status_next = STAT_OK;
                res_idx_next    = '0;
                res_key_next    = '0;
                if (op_reg == OP_CLEAR) begin
                    cnt_clr = 1'b1;
                end else if ((op_reg == OP_ADD || op_reg == OP_GET) && !cat_ok) begin
                    res_status_next = STAT_BAD_CAT;
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    res_idx_next = INDEX_W'(cmp_idx_reg);
                end else if (more) begin
                    ram_re       = 1'b1;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = IDX_W'(rd_idx_reg);
                end else if (cmp_vld_reg) begin
                    cmp_vld_next = 1'b0;
                end else if (full) begin
                    res_status_next = STAT_FULL;
                end else begin
                    ram_we       = 1'b1;
                    cnt_inc      = 1'b1;
                    res_idx_next = INDEX_W'(n_reg);
                end
            end
            ST_GET_RD: begin
                ram_raddr = base_reg + ADDR_W'(slot_reg);
                if (slot_ok) begin
                    ram_re = 1'b1;
                end else begin
                    res_status_next = STAT_UNFILLED;
                end
            end
            ST_GET_WAIT: begin
                res_key_next = KEY_FIELD_W'(ram_rdata);
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_idx_next    = res_idx_reg;
                    m_key_next    = res_key_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
            for (int c = 0; c < CATEGORIES; c++) begin
                cnt_reg[c] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cmp_vld_reg <= cmp_vld_next;
            if (cnt_clr) begin
                for (int c = 0; c < CATEGORIES; c++) begin
                    cnt_reg[c] <= '0;
                end
            end else if (cnt_inc) begin
                cnt_reg[cat_idx] <= n_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= op_t'(s_axis_tuser[OP_W-1:0]);
            cat_reg  <= s_axis_tuser[OP_W+CAT_FIELD_W-1:OP_W];
            key_reg  <= s_axis_tdata[KEY_WIDTH-1:0];
            slot_reg <= s_axis_tdata[KEY_FIELD_W+SLOT_W-1:KEY_FIELD_W];
        end
        n_reg          <= n_next;
        base_reg       <= base_next;
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_key_reg    <= res_key_next;
        m_status_reg   <= m_status_next;
        m_idx_reg      <= m_idx_next;
        m_key_reg      <= m_key_next;
    end

endmodule

// ===== design/cit_checker.sv =====
`include "assert_macros.svh"

module cit_checker import cit_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    logic                              out_stall;
    logic                              out_err;
    logic [INDEX_W-1:0]                out_idx;
    logic [M_TDATA_W-INDEX_W-1:0]      out_key;
    logic [M_TUSER_W+M_TDATA_W-1:0]    out_word;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_err   = (m_axis_tuser != STAT_OK);
    assign out_idx   = m_axis_tdata[INDEX_W-1:0];
    assign out_key   = m_axis_tdata[M_TDATA_W-1:INDEX_W];
    assign out_word  = {m_axis_tuser, m_axis_tdata};

    // A stalled result word must hold still until it is taken.
    `AST_NEXT(a_out_hold, aclk, aresetn, out_stall, m_axis_tvalid && $stable(out_word))

    // Every error status comes with all-zero data.
    `AST_IMPLY(a_err_zero, aclk, aresetn, m_axis_tvalid && out_err, m_axis_tdata == '0)

    // An index and a key are never reported together.
    `AST_IMPLY(a_idx_or_key, aclk, aresetn, m_axis_tvalid && out_idx != '0, out_key == '0)

    // After taking a word the block is busy in the cycle that follows.
    `AST_NEXT(a_busy_after, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind categorized_intern_table_top cit_checker u_cit_checker (.*);

// ===== dv/categorized_intern_table_top_test.sv =====
`timescale 1ns / 1ps

module categorized_intern_table_top_test;
    import cit_pkg::*;

    typedef struct packed {
        status_t    status;
        logic [7:0] index;
        logic [63:0] key;
    } result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // key[63:0], slot[71:64]
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;  // op[1:0], category[4:2]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;       // found_index[7:0], stored_key[71:8]
    logic [M_TUSER_W-1:0] m_axis_tuser;       // status[1:0]

    logic [63:0] table_keys [CIT_CATEGORIES][CIT_CAPACITY];
    int          table_fill [CIT_CATEGORIES];
    logic [63:0] key_pool [8];
    result_t     pending_results [$];
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          err_count = 0;

    categorized_intern_table_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("FAIL categorized_intern_table_top");
        $finish;
    end

    function automatic result_t intern_lookup(op_t op, logic [2:0] cat, logic [63:0] key,
                                              logic [7:0] slot);
        result_t r;
        int      n;
        int      hit;
        r.status = STAT_OK;
        r.index  = 8'd0;
        r.key    = 64'd0;
        hit      = -1;
        case (op)
            OP_CLEAR: begin
                foreach (table_fill[c]) table_fill[c] = 0;
            end
            OP_NONE: begin
            end
            default: begin
                if (cat >= CIT_CATEGORIES) begin
                    r.status = STAT_BAD_CAT;
                end else if (op == OP_ADD) begin
                    n = table_fill[cat];
                    for (int i = 0; i < n; i++) begin
                        if (hit < 0 && table_keys[cat][i] == key) hit = i;
                    end
                    if (hit >= 0) begin
                        r.index = hit[7:0];
                    end else if (n >= CIT_CAPACITY) begin
                        r.status = STAT_FULL;
                    end else begin
                        table_keys[cat][n] = key;
                        table_fill[cat] = n + 1;
                        r.index = n[7:0];
                    end
                end else if (slot >= table_fill[cat]) begin
                    r.status = STAT_UNFILLED;
                end else begin
                    r.key = table_keys[cat][slot];
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        if (err_count <= 40) $display("%0t: %s mismatch: got %h, expected %h",
                                      $realtime, what, got, want);
    endtask

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata[63:0], 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser[1:0] != want.status)
                    report_mismatch("status", 64'(m_axis_tuser[1:0]), 64'(want.status));
                if (m_axis_tdata[7:0] != want.index)
                    report_mismatch("found_index", 64'(m_axis_tdata[7:0]), 64'(want.index));
                if (m_axis_tdata[71:8] != want.key)
                    report_mismatch("stored_key", m_axis_tdata[71:8], want.key);
            end
        end
    end

    task automatic send_word(op_t op, logic [2:0] cat, logic [63:0] key, logic [7:0] slot);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {slot, key};
        s_axis_tuser  <= {cat, op};
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(intern_lookup(op, cat, key, slot));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic test_directed();
        logic [63:0] k;
        k = {$urandom, $urandom};
        send_word(OP_GET, 3'd0, 64'd0, 8'd0);
        send_word(OP_ADD, 3'd0, 64'd0, 8'd0);
        send_word(OP_ADD, 3'd0, '1, 8'hff);
        send_word(OP_ADD, 3'd0, 64'd0, 8'd0);
        send_word(OP_ADD, 3'd0, '1, 8'd0);
        send_word(OP_GET, 3'd0, '1, 8'd0);
        send_word(OP_GET, 3'd0, 64'd0, 8'd1);
        send_word(OP_GET, 3'd0, 64'd0, 8'd2);
        send_word(OP_GET, 3'd0, 64'd0, 8'hff);
        send_word(OP_ADD, 3'd7, k, 8'd0);
        send_word(OP_GET, 3'd7, k, 8'd0);
        send_word(OP_ADD, 3'd6, k, 8'd0);
        send_word(OP_GET, 3'd6, 64'd0, 8'd0);
        send_word(OP_NONE, 3'd5, k, 8'h5a);
        send_word(OP_NONE, 3'd7, '1, 8'hff);
        send_word(OP_CLEAR, 3'd7, '1, 8'hff);
        send_word(OP_GET, 3'd0, 64'd0, 8'd0);
        send_word(OP_GET, 3'd6, 64'd0, 8'd0);
        send_word(OP_ADD, 3'd0, '1, 8'd0);
        send_word(OP_GET, 3'd0, 64'd0, 8'd0);
        wait_drained();
    endtask

    task automatic test_table_full();
        logic [2:0] cat;
        cat = 3'($urandom_range(CIT_CATEGORIES - 1));
        while (table_fill[cat] < CIT_CAPACITY)
            send_word(OP_ADD, cat, {$urandom, $urandom}, 8'($urandom_range(255)));
        send_word(OP_ADD, cat, {$urandom, $urandom}, 8'd0);
        send_word(OP_ADD, cat, table_keys[cat][CIT_CAPACITY-1], 8'd0);
        send_word(OP_ADD, cat, table_keys[cat][0], 8'd0);
        send_word(OP_GET, cat, 64'd0, 8'hff);
        send_word(OP_GET, cat, 64'd0, 8'd0);
        wait_drained();
        send_word(OP_CLEAR, cat, 64'd0, 8'd0);
    endtask

    task automatic test_random_traffic(int count);
        int          pick;
        logic [2:0]  cat;
        logic [63:0] key;
        logic [7:0]  slot;
        for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = 64'd0;
        key_pool[1] = '1;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            cat  = 3'($urandom_range(CIT_CATEGORIES - 1));
            key  = ($urandom_range(1) != 0) ? key_pool[$urandom_range(7)]
                                             : {$urandom, $urandom};
            slot = 8'($urandom_range(255));
            if (pick < 7) begin
                send_word(OP_CLEAR, 3'($urandom_range(7)), key, slot);
            end else if (pick < 9) begin
                send_word(OP_NONE, 3'($urandom_range(7)), key, slot);
            end else if (pick < 14) begin
                send_word(($urandom_range(1) != 0) ? OP_ADD : OP_GET, 3'd7, key, slot);
            end else if (pick < 60) begin
                send_word(OP_ADD, cat, key, slot);
            end else begin
                if (table_fill[cat] > 0 && $urandom_range(3) != 0)
                    slot = 8'($urandom_range(table_fill[cat] - 1));
                send_word(OP_GET, cat, key, slot);
            end
            if ($urandom_range(39) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_pct = 16;
        snk_idle_pct = 68;
        test_directed();
        test_random_traffic(380);
        src_idle_pct = 68;
        snk_idle_pct = 16;
        test_table_full();
        test_random_traffic(380);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_traffic(380);
        wait_drained();
        repeat (CIT_CAPACITY + 16) @(posedge aclk);
        if (err_count == 0) begin
            $display("PASS categorized_intern_table_top");
        end else begin
            $display("FAIL categorized_intern_table_top");
        end
        $finish;
    end

endmodule
